>>> hw/rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Beat types, initial hash values, round constants and sigma functions
// for the SHA-512 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha512_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned NUM_HASH = 8;
	localparam int unsigned NUM_BLK  = 16;
	localparam int unsigned ROUNDS   = 80;

	localparam logic [6:0]  CNT_LEN_START = 7'd120;  // first byte of the 64-bit length
	localparam logic [6:0]  CNT_SPILL     = 7'd112;  // no room left for the length field
	localparam logic [6:0]  CNT_LAST      = 7'd127;
	localparam logic [6:0]  RND_LAST      = 7'd79;
	localparam logic [7:0]  PAD_BYTE      = 8'h80;
	localparam logic [63:0] BLOCK_BITS    = 64'd1024;

	typedef struct packed {
		logic       kind;       // 0 = data byte, 1 = finish
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        last_word;
	} out_item_t;

	localparam logic [63:0] IV [NUM_HASH] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] ROUND_K [ROUNDS] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] round_k(input logic [6:0] idx);
		logic [63:0] k;
		k = 64'd0;
		if (idx <= RND_LAST) begin
			k = ROUND_K[idx];
		end
		return k;
	endfunction

	function automatic logic [63:0] big_sigma0(input logic [63:0] x);
		return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [63:0] big_sigma1(input logic [63:0] x);
		return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] small_sigma0(input logic [63:0] x);
		return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic logic [63:0] small_sigma1(input logic [63:0] x);
		return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sha512_hash_engine.sv
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 hash engine: byte-wide message input, 64-bit digest word output,
// one compression round per cycle on a single round datapath.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat        | fields
//   --------+-----------+-------------+-------------------------------
//   in      | input     | in_item_t   | kind, data_byte
//   out     | output    | out_item_t  | digest_word, last_word
//
// The 128th byte of a block starts a compression: a load step copies the
// hash into a..h, 80 rounds run through the one round datapath, and a fold
// step adds a..h back into the hash. A finish beat shifts padding and the
// length in one byte a cycle up to the block end, runs one or two
// compressions, then offers eight digest beats, one per accepted beat.
// Reset clears control state and loads the initial hash values; the block
// buffer and a..h are not reset. in_ready is low from a block end or finish
// until the engine is back in idle; a stalled output simply holds its word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_hash_engine (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire sha512_pkg::in_item_t   in_item,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output sha512_pkg::out_item_t       out_item
);

	import sha512_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_LEN   = 7'b0000100,
		ST_LOAD  = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_FOLD  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [6:0]  cnt_q;        // bytes held in the block buffer
	logic [6:0]  rnd_q;        // round index
	logic [2:0]  emit_q;       // digest word on the output
	logic [63:0] bit_len_q;
	logic        fin_q;        // finish in progress
	logic        spill_q;      // padding runs into a second block
	logic        last_q;       // block in flight is the final one
	logic [63:0] hash_q [NUM_HASH];
	logic [63:0] blk_q  [NUM_BLK];  // 1024-bit shift buffer, byte 0 ends in blk_q[0][63:56]
	logic [63:0] var_q  [NUM_HASH]; // a..h

	logic        in_acc;
	logic        out_acc;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic        pad_to_len;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] w_next;
	logic [63:0] ch;
	logic [63:0] maj;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign out_item.digest_word = hash_q[0];
	assign out_item.last_word   = (emit_q == 3'd7);

	// padding stops at the length field unless it must first fill this block
	assign pad_to_len = (cnt_q == CNT_LEN_START) && !spill_q;

	// one byte a cycle goes into the block buffer while shift_en is high
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = 8'd0;
		unique case (state_q)
			ST_IDLE: begin
				shift_en   = in_acc;
				shift_byte = in_item.kind ? PAD_BYTE : in_item.data_byte;
			end
			ST_PAD: begin
				shift_en   = !pad_to_len;
				shift_byte = 8'd0;
			end
			ST_LEN: begin
				shift_en   = 1'b1;
				shift_byte = bit_len_q[63:56];
			end
			ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT: begin
				shift_en   = 1'b0;
				shift_byte = 8'd0;
			end
			default: begin
				shift_en   = 1'b0;
				shift_byte = 8'd0;
			end
		endcase
	end

	// round datapath: blk_q[0] is W[t], window holds W[t..t+15]
	always_comb begin
		ch     = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		maj    = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1     = var_q[7] + big_sigma1(var_q[4]) + ch + round_k(rnd_q) + blk_q[0];
		t2     = big_sigma0(var_q[0]) + maj;
		w_next = small_sigma1(blk_q[14]) + blk_q[9] + small_sigma0(blk_q[1]) + blk_q[0];
	end

	// control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= 7'd0;
			rnd_q     <= 7'd0;
			emit_q    <= 3'd0;
			bit_len_q <= 64'd0;
			fin_q     <= 1'b0;
			spill_q   <= 1'b0;
			last_q    <= 1'b0;
			for (int i = 0; i < NUM_HASH; i++) begin
				hash_q[i] <= IV[i];
			end
		end else begin
			if (shift_en) begin
				cnt_q <= cnt_q + 7'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_item.kind) begin
							fin_q     <= 1'b1;
							spill_q   <= (cnt_q >= CNT_SPILL);
							bit_len_q <= bit_len_q + {54'd0, cnt_q, 3'd0};
							state_q   <= (cnt_q == CNT_LAST) ? ST_LOAD : ST_PAD;
						end else if (cnt_q == CNT_LAST) begin
							bit_len_q <= bit_len_q + BLOCK_BITS;
							state_q   <= ST_LOAD;
						end
					end
				end
				ST_PAD: begin
					if (pad_to_len) begin
						state_q <= ST_LEN;
					end else if (cnt_q == CNT_LAST) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LEN: begin
					// shifting the length out leaves it zero for the next message
					bit_len_q <= {bit_len_q[55:0], 8'd0};
					if (cnt_q == CNT_LAST) begin
						last_q  <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= 7'd0;
					spill_q <= 1'b0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < NUM_HASH; i++) begin
						hash_q[i] <= hash_q[i] + var_q[i];
					end
					emit_q <= 3'd0;
					if (last_q) begin
						state_q <= ST_EMIT;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						// shift the digest out; IV words follow it in
						for (int i = 0; i < NUM_HASH - 1; i++) begin
							hash_q[i] <= hash_q[i + 1];
						end
						hash_q[NUM_HASH - 1] <= IV[emit_q];
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							fin_q   <= 1'b0;
							last_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block buffer and working variables
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < NUM_BLK - 1; i++) begin
				blk_q[i] <= {blk_q[i][55:0], blk_q[i + 1][63:56]};
			end
			blk_q[NUM_BLK - 1] <= {blk_q[NUM_BLK - 1][55:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < NUM_BLK - 1; i++) begin
				blk_q[i] <= blk_q[i + 1];
			end
			blk_q[NUM_BLK - 1] <= w_next;
		end

		if (state_q == ST_LOAD) begin
			for (int i = 0; i < NUM_HASH; i++) begin
				var_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

`ifndef SYNTH
	a_fold_after_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> ($past(state_q) == ST_ROUND && $past(rnd_q) == RND_LAST))
		else $error("fold entered without a full round sequence");

	a_emit_state_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q == 7'd0 && bit_len_q == 64'd0 && !in_ready))
		else $error("digest offered with message state not cleared");

	a_finish_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_item.kind) |=> (!in_ready && fin_q))
		else $error("finish beat did not start padding");

	a_load_on_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (cnt_q == 7'd0 && $past(shift_en || in_acc)))
		else $error("compression started on a partial block");
`endif

endmodule

`default_nettype wire
